FILE: rtl/dual_policy_service_queue_core_assert.svh
`ifndef DUAL_POLICY_SERVICE_QUEUE_CORE_ASSERT_SVH
`define DUAL_POLICY_SERVICE_QUEUE_CORE_ASSERT_SVH
// implication checked at every edge outside reset
`define DPSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsq assertion failed");
// implication whose consequent is checked in the following cycle
`define DPSQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsq assertion failed");
`endif

FILE: rtl/dpsq_pkg.sv
package dpsq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  localparam logic [1:0] FN_ARRIVE = 2'd0;
  localparam logic [1:0] FN_OLDEST = 2'd1;

  localparam logic [1:0] ST_ARRIVED = 2'd0;
  localparam logic [1:0] ST_SERVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ticket;
  } out_item_t;

  typedef struct packed {
    logic        live;
    logic [31:0] value;
    logic [31:0] ticket;
  } entry_t;

  typedef enum logic [1:0] {CELL_HOLD, CELL_ROT, CELL_DEL, CELL_WR} cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      wr_value;
    logic [31:0]      wr_ticket;
  } cell_ctrl_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DEL} fsm_state_t;

endpackage

FILE: rtl/dpsq_cell.sv
module dpsq_cell
  import dpsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  cell_ctrl_t       ctrl,
  input  entry_t           nb_entry,
  output entry_t           cur_entry
);

  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      CELL_ROT: ent_nxt = nb_entry;
      CELL_DEL: if (my_idx >= ctrl.idx) ent_nxt = nb_entry;
      CELL_WR: begin
        if (my_idx == ctrl.idx) begin
          ent_nxt.live   = 1'b1;
          ent_nxt.value  = ctrl.wr_value;
          ent_nxt.ticket = ctrl.wr_ticket;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // live flag is control state; value and ticket only matter while live
  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.live <= 1'b0;
    else        ent_r.live <= ent_nxt.live;
    ent_r.value  <= ent_nxt.value;
    ent_r.ticket <= ent_nxt.ticket;
  end

  assign cur_entry = ent_r;

endmodule

FILE: rtl/dual_policy_service_queue_core.sv
// Dual-policy service queue: up to CAPACITY waiting items, each tagged with a
// sequential ticket (first ticket 1, wraps at 2^32). func 0 stores a value,
// func 1 serves the oldest entry, func 2 (and 3) serves the largest value with
// the oldest winning ties. Every input item yields exactly one result item.
// Arrivals, serve-oldest and any serve on an empty queue complete in the idle state.
// Serve-best takes the item, rotates the row of cells once around past a
// single comparator at cell 0 (state S_SCAN), and then removes the winner
// (state S_DEL); no new item is taken until it is done.
// No clearing pass after reset; the queue is usable at once.
module dual_policy_service_queue_core
  import dpsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "dual_policy_service_queue_core_assert.svh"

  // Entries are kept compacted in arrival order: cell 0 is the oldest,
  // cells at index >= occupied are not live.
  entry_t     ent [CAPACITY];
  entry_t     last_nb;
  cell_ctrl_t ctrl;

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [31:0]      next_ticket_r, next_ticket_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             have_r, have_nxt;
  logic [31:0]      best_val_r, best_val_nxt;
  logic [31:0]      best_tkt_r, best_tkt_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             accept, take;

  // ring closes only while rotating; a delete shifts in an empty entry
  assign last_nb = (ctrl.op == CELL_ROT) ? ent[0] : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t nb;
    if (i == CAPACITY - 1) begin : g_last
      assign nb = last_nb;
    end else begin : g_mid
      assign nb = ent[i+1];
    end
    dpsq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .my_idx    (IDX_W'(i)),
      .ctrl      (ctrl),
      .nb_entry  (nb),
      .cur_entry (ent[i])
    );
  end

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  // strictly greater: earlier (older) entry keeps a tie
  assign take     = ent[0].live && (!have_r || (ent[0].value > best_val_r));

  always_comb begin
    state_nxt       = state_r;
    occ_nxt         = occ_r;
    next_ticket_nxt = next_ticket_r;
    cnt_nxt         = cnt_r;
    have_nxt        = have_r;
    best_val_nxt    = best_val_r;
    best_tkt_nxt    = best_tkt_r;
    best_idx_nxt    = best_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    ctrl            = '{op: CELL_HOLD, idx: '0, wr_value: in_data.value,
                        wr_ticket: next_ticket_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FN_ARRIVE: begin
              out_valid_nxt = 1'b1;
              if (occ_r == CNT_W'(CAPACITY)) begin
                out_data_nxt = '{status: ST_FULL, ticket: '0};
              end else begin
                ctrl.op         = CELL_WR;
                ctrl.idx        = occ_r[IDX_W-1:0];
                occ_nxt         = occ_r + 1'b1;
                next_ticket_nxt = next_ticket_r + 32'd1;
                out_data_nxt    = '{status: ST_ARRIVED, ticket: next_ticket_r};
              end
            end
            FN_OLDEST: begin
              out_valid_nxt = 1'b1;
              if (occ_r == '0) begin
                out_data_nxt = '{status: ST_EMPTY, ticket: '0};
              end else begin
                ctrl.op      = CELL_DEL;
                ctrl.idx     = '0;
                occ_nxt      = occ_r - 1'b1;
                out_data_nxt = '{status: ST_SERVED, ticket: ent[0].ticket};
              end
            end
            default: begin
              if (occ_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_EMPTY, ticket: '0};
              end else begin
                state_nxt = S_SCAN;
                cnt_nxt   = '0;
                have_nxt  = 1'b0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // one full turn of the ring; cnt is the original position at cell 0
        ctrl.op = CELL_ROT;
        if (take) begin
          have_nxt     = 1'b1;
          best_val_nxt = ent[0].value;
          best_tkt_nxt = ent[0].ticket;
          best_idx_nxt = cnt_r;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(CAPACITY - 1)) state_nxt = S_DEL;
      end
      S_DEL: begin
        ctrl.op       = CELL_DEL;
        ctrl.idx      = best_idx_r;
        occ_nxt       = occ_r - 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_SERVED, ticket: best_tkt_r};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      occ_r         <= '0;
      next_ticket_r <= 32'd1;
      cnt_r         <= '0;
      have_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      occ_r         <= occ_nxt;
      next_ticket_r <= next_ticket_nxt;
      cnt_r         <= cnt_nxt;
      have_r        <= have_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    best_tkt_r <= best_tkt_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DPSQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= CNT_W'(CAPACITY))
  `DPSQ_ASSERT_IMP(a_no_out_in_scan, state_r == S_SCAN, !out_valid_r)
  `DPSQ_ASSERT_NXT(a_arrive_count,
    accept && in_data.func == FN_ARRIVE && occ_r != CNT_W'(CAPACITY),
    occ_r == $past(occ_r) + 1'b1)
  `DPSQ_ASSERT_NXT(a_scan_found, state_r == S_SCAN && cnt_r == IDX_W'(CAPACITY - 1),
    have_r)

endmodule

FILE: sim/tb_dual_policy_service_queue_core.sv
`timescale 1ns / 100ps

module tb_dual_policy_service_queue_core;
  import dpsq_pkg::*;

  localparam logic [1:0] FN_BEST   = 2'd2;
  localparam logic [1:0] FN_SPARE  = 2'd3;
  localparam int         NUM_RAND  = 270;

  // Ticket ledger: mirrors the queue contents and predicts each result.
  class ticket_ledger;
    logic [31:0] val_q[$];
    logic [31:0] tkt_q[$];
    logic [31:0] next_tkt;
    out_item_t   pending[$];
    int          errors;
    int          checked;

    function new();
      next_tkt = 32'd1;
      errors   = 0;
      checked  = 0;
    endfunction

    // Entries are kept in arrival order, so the oldest is the head and the
    // first maximum found is the oldest among equal values.
    function void note_item(in_item_t it);
      out_item_t r;
      int        pick;
      r.status = ST_EMPTY;
      r.ticket = '0;
      if (it.func == FN_ARRIVE) begin
        if (val_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          val_q = {val_q, it.value};
          tkt_q = {tkt_q, next_tkt};
          r.status = ST_ARRIVED;
          r.ticket = next_tkt;
          next_tkt = next_tkt + 32'd1;
        end
      end else if (val_q.size() != 0) begin
        pick = 0;
        if (it.func != FN_OLDEST) begin
          for (int i = 1; i < val_q.size(); i++) begin
            if (val_q[i] > val_q[pick]) pick = i;
          end
        end
        r.status = ST_SERVED;
        r.ticket = tkt_q[pick];
        val_q.delete(pick);
        tkt_q.delete(pick);
      end
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d ticket %0h",
                                   got.status, got.ticket);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status || got.ticket !== exp_r.ticket) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp status %0d ticket %0h, got status %0d ticket %0h",
                   checked, exp_r.status, exp_r.ticket, got.status, got.ticket);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  ticket_ledger ledger;
  bit           hold_sink;   // long receiver hold-off in progress
  bit           drain_done;

  dual_policy_service_queue_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and holds it until accepted; the ledger notes it at the
  // accepting edge. Valid drops only ahead of a gap or through stop_input.
  task automatic send_item(logic [1:0] fn, logic [31:0] v, bit allow_gap);
    in_item_t it;
    int       g;
    it.func  = fn;
    it.value = v;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(it);
  endtask

  // Ends a burst of items: valid is driven low.
  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random values lean on ties and extremes so the tie-break is exercised.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 7);
      1:       return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, plus the long hold-off requested by the sender.
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result monitor samples at the edge, after all drivers settled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(out_data);
  end

  // Holds the receiver off while the sender pushes; the argument sets how long.
  task automatic sink_hold(int cycles);
    hold_sink = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_sink = 1'b0;
  endtask

  initial begin
    int fn_pick;
    ledger     = new();
    hold_sink  = 1'b0;
    drain_done = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: serves on an empty queue, extremes, ties, unused selector.
    send_item(FN_OLDEST, 32'hFFFF_FFFF, 1'b0);
    send_item(FN_BEST,   32'h0,         1'b0);
    send_item(FN_SPARE,  32'h1234_5678, 1'b0);
    send_item(FN_ARRIVE, 32'h0,         1'b0);
    send_item(FN_ARRIVE, 32'hFFFF_FFFF, 1'b0);
    send_item(FN_ARRIVE, 32'hFFFF_FFFF, 1'b0);
    send_item(FN_ARRIVE, 32'h5555_5555, 1'b0);
    send_item(FN_ARRIVE, 32'hAAAA_AAAA, 1'b0);
    send_item(FN_BEST,   32'h0,         1'b0);  // tie: earlier max wins
    send_item(FN_SPARE,  32'hFFFF_FFFF, 1'b0);
    send_item(FN_OLDEST, 32'h0,         1'b0);
    send_item(FN_BEST,   32'h0,         1'b0);
    send_item(FN_OLDEST, 32'h0,         1'b0);
    send_item(FN_OLDEST, 32'h0,         1'b0);  // empty again

    // Fill to capacity while the receiver is held off: input must stall.
    fork
      sink_hold(400);
      begin
        repeat (CAPACITY + 3) send_item(FN_ARRIVE, rand_value(), 1'b0);
        stop_input();
      end
    join
    send_item(FN_BEST,   32'h0, 1'b0);
    send_item(FN_ARRIVE, 32'h7,  1'b0);
    send_item(FN_ARRIVE, 32'h8,  1'b0);  // full again, dropped
    repeat (CAPACITY) send_item(FN_OLDEST, 32'h0, 1'b1);

    // Random: mostly arrivals and cheap serves; serve-best costs a scan.
    for (int n = 0; n < NUM_RAND; n++) begin
      fn_pick = $urandom_range(0, 99);
      if (fn_pick < 50)      send_item(FN_ARRIVE, rand_value(), 1'b1);
      else if (fn_pick < 78) send_item(FN_OLDEST, $urandom(), 1'b1);
      else if (fn_pick < 96) send_item(FN_BEST,   $urandom(), 1'b1);
      else                   send_item(FN_SPARE,  $urandom(), 1'b1);
    end
    stop_input();

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (CAPACITY + 20) @(posedge clk);
    drain_done = 1'b1;
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest run (all serves scanning, all stalls).
  initial begin
    #20ms;
    if (!drain_done) $display("FAILURE");
    $finish;
  end

endmodule
